@@ rtl/core/bskic_pkg.sv @@
// Package for the base-sigma k-mer index codec: widths, codes, state type
// and small saturation helpers shared by every file under rtl/core.
// No dependencies.
`default_nettype none

package bskic_pkg;

	// Packed index width carried through the arithmetic (16 to 64)
	localparam int INDEX_WIDTH = 64;

	// Fixed field widths of the channels
	localparam int IDX_FIELD_W = 64;
	localparam int DIGIT_W     = 8;
	localparam int LEN_W       = 7;
	localparam int RADIX_W     = 9;

	// Divider works one bit wider so that 2^INDEX_WIDTH itself can be divided
	localparam int DIV_W     = INDEX_WIDTH + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int PROD_W    = INDEX_WIDTH + RADIX_W;

	// Digit store: one entry per digit position of the longest string
	localparam int MEM_DEPTH = 64;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	localparam logic [IDX_FIELD_W-1:0] IDX_MASK =
		{IDX_FIELD_W{1'b1}} >> (IDX_FIELD_W - INDEX_WIDTH);
	localparam logic [DIV_W-1:0]   FULL_SCALE  = {1'b1, {INDEX_WIDTH{1'b0}}};
	localparam logic [LEN_W-1:0]   COUNT_SAT   = '1;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX   = '1;
	localparam logic [RADIX_W-1:0] ALPHA_RESET = RADIX_W'(4);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);

	// Request and result codes
	localparam logic REQ_ENCODE  = 1'b0;
	localparam logic REQ_DECODE  = 1'b1;
	localparam logic KIND_INDEX  = 1'b0;
	localparam logic KIND_DIGIT  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ML_INIT,
		ST_ML_RUN,
		ST_DEC_DIV,
		ST_DEC_WAIT,
		ST_DEC_RD,
		ST_DEC_OUT
	} state_t;

	// Divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Encode accumulator strobes
	typedef struct packed {
		logic take;
		logic last;
	} enc_ctrl_t;

	// Radix in use: values below two act as two
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] a);
		eff_radix = (a < RADIX_MIN) ? RADIX_MIN : a;
	endfunction

	function automatic logic [DIGIT_W-1:0] sat_rem(input logic [RADIX_W-1:0] v);
		sat_rem = (v > RADIX_W'(DIGIT_MAX)) ? DIGIT_MAX : v[DIGIT_W-1:0];
	endfunction

	function automatic logic [DIGIT_W-1:0] sat_wide(input logic [DIV_W-1:0] v);
		sat_wide = (v > DIV_W'(DIGIT_MAX)) ? DIGIT_MAX : v[DIGIT_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/bskic_if.sv @@
// Valid/ready channel interfaces for the codec: request and result.
// Depends on bskic_pkg.
`default_nettype none

interface bskic_req_if;
	import bskic_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [DIGIT_W-1:0]     digit_in;
	logic                   last_digit;
	logic [IDX_FIELD_W-1:0] index_in;
	logic [LEN_W-1:0]       length_in;

	modport source (
		output valid, req_type, digit_in, last_digit, index_in, length_in,
		input  ready
	);
	modport sink (
		input  valid, req_type, digit_in, last_digit, index_in, length_in,
		output ready
	);
endinterface

interface bskic_res_if;
	import bskic_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   result_kind;
	logic [IDX_FIELD_W-1:0] index_out;
	logic [DIGIT_W-1:0]     digit_out;
	logic                   last_out;
	logic                   error_flag;

	modport source (
		output valid, result_kind, index_out, digit_out, last_out, error_flag,
		input  ready
	);
	modport sink (
		input  valid, result_kind, index_out, digit_out, last_out, error_flag,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/bskic_div_unit.sv @@
// Shared restoring divider, one quotient bit per cycle, DIV_W steps.
// Used for the maximum-length search and for decode. Depends on bskic_pkg.
`default_nettype none

module bskic_div_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [bskic_pkg::DIV_W-1:0]   dividend,
	input  wire logic [bskic_pkg::RADIX_W-1:0] divisor,
	output logic [bskic_pkg::DIV_W-1:0]        quotient,
	output logic [bskic_pkg::RADIX_W-1:0]      remainder,
	output bskic_pkg::div_stat_t               stat
);
	import bskic_pkg::*;

	logic [DIV_W-1:0]     dvd_q;
	logic [RADIX_W-1:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RADIX_W:0]     shifted;
	logic [RADIX_W:0]     diff;
	logic                 ge;
	logic [RADIX_W-1:0]   rem_nxt;

	// One compare-subtract step
	always_comb begin
		shifted = {rem_q, dvd_q[DIV_W-1]};
		diff    = shifted - {1'b0, divisor};
		ge      = shifted >= {1'b0, divisor};
		rem_nxt = ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DIV_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient  = dvd_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

@@ rtl/core/bskic_enc_acc.sv @@
// Encode accumulator: Horner step index*sigma + digit, digit count and the
// sticky string error. Depends on bskic_pkg.
`default_nettype none

module bskic_enc_acc (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bskic_pkg::enc_ctrl_t         ctrl,
	input  wire logic [bskic_pkg::DIGIT_W-1:0] digit,
	input  wire logic [bskic_pkg::RADIX_W-1:0] radix,
	input  wire logic [bskic_pkg::LEN_W-1:0]   max_len,
	output logic [bskic_pkg::INDEX_WIDTH-1:0]  index_nxt,
	output logic                               err_nxt
);
	import bskic_pkg::*;

	logic [INDEX_WIDTH-1:0] run_q;
	logic [LEN_W-1:0]       cnt_q;
	logic                   err_q;
	logic [PROD_W-1:0]      prod;
	logic [LEN_W-1:0]       cnt_nxt;

	// Multiply-accumulate, wrapping at the index width
	always_comb begin
		prod      = PROD_W'(run_q) * PROD_W'(radix);
		index_nxt = INDEX_WIDTH'(prod + PROD_W'(digit));
		cnt_nxt   = (cnt_q == COUNT_SAT) ? COUNT_SAT : cnt_q + LEN_W'(1);
		err_nxt   = err_q || ({1'b0, digit} >= radix) || (cnt_nxt > max_len);
	end

	// String state, cleared after the last digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			cnt_q <= '0;
			err_q <= 1'b0;
		end else if (ctrl.take) begin
			if (ctrl.last) begin
				run_q <= '0;
				cnt_q <= '0;
				err_q <= 1'b0;
			end else begin
				run_q <= index_nxt;
				cnt_q <= cnt_nxt;
				err_q <= err_nxt;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/bskic_digit_mem.sv @@
// Decoded digit store, one write and one registered read port.
// Depends on bskic_pkg.
`default_nettype none

module bskic_digit_mem (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [bskic_pkg::MEM_AW-1:0]  waddr,
	input  wire logic [bskic_pkg::DIGIT_W-1:0] wdata,
	input  wire logic                         re,
	input  wire logic [bskic_pkg::MEM_AW-1:0]  raddr,
	output logic [bskic_pkg::DIGIT_W-1:0]      rdata
);
	import bskic_pkg::*;

	logic [DIGIT_W-1:0] mem [MEM_DEPTH];
	logic [DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/base_sigma_kmer_index_codec_top.sv @@
// Top level of the base-sigma k-mer index codec: sequencer, output register
// and assertions. Depends on bskic_pkg, bskic_if, bskic_div_unit,
// bskic_enc_acc and bskic_digit_mem.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------------
//  req      | in  | valid/ready         | req_type digit_in last_digit index_in length_in
//  res      | out | valid/ready         | result_kind index_out digit_out last_out error_flag
//  cfg      | in  | cfg_we, no stall    | cfg_wdata (alphabet size)
//
// Encode request: each digit is taken in ST_IDLE; the last digit puts an index
// result into the output register. Decode request of length L: L-1 divisions
// on the shared divider, then the digits leave one at a time, each waiting for
// a free output register. After reset and after every configuration write the
// maximum length is searched on the same divider, up to 65 divisions (radix
// two); no request is taken meanwhile.
// A request is taken only while the output register is free or being drained.
`default_nettype none

module base_sigma_kmer_index_codec_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bskic_req_if.sink                          req,
	bskic_res_if.source                        res,
	input  wire logic                          cfg_we,
	input  wire logic [bskic_pkg::RADIX_W-1:0] cfg_wdata
);
	import bskic_pkg::*;

	state_t state_q, state_d;

	logic [RADIX_W-1:0] alpha_q;
	logic [RADIX_W-1:0] radix;
	logic [LEN_W-1:0]   max_len_q;

	// Decode working registers
	logic [DIV_W-1:0]  dec_val_q;
	logic [MEM_AW-1:0] dec_cnt_q;
	logic [MEM_AW-1:0] dec_lastpos_q;
	logic              dec_err_q;
	logic [LEN_W-1:0]  len_m1;

	// Divider
	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_quot;
	logic [RADIX_W-1:0] div_rem;
	div_stat_t         div_stat;

	// Encode
	enc_ctrl_t              enc_ctrl;
	logic [INDEX_WIDTH-1:0] enc_index_nxt;
	logic                   enc_err_nxt;

	// Digit store
	logic               mem_we;
	logic               mem_re;
	logic [DIGIT_W-1:0] mem_rdata;

	// Handshake and output register
	logic                   in_ready;
	logic                   accept;
	logic                   slot_free;
	logic                   out_load;
	logic                   out_kind;
	logic [IDX_FIELD_W-1:0] out_index;
	logic [DIGIT_W-1:0]     out_digit;
	logic                   out_last;
	logic                   out_err;
	logic                   res_valid_q;
	logic                   res_kind_q;
	logic [IDX_FIELD_W-1:0] res_index_q;
	logic [DIGIT_W-1:0]     res_digit_q;
	logic                   res_last_q;
	logic                   res_err_q;

	assign radix     = eff_radix(alpha_q);
	assign slot_free = !res_valid_q || res.ready;
	assign len_m1    = req.length_in - LEN_W'(1);

	bskic_div_unit u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (radix),
		.quotient  (div_quot),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	bskic_enc_acc u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (enc_ctrl),
		.digit     (req.digit_in),
		.radix     (radix),
		.max_len   (max_len_q),
		.index_nxt (enc_index_nxt),
		.err_nxt   (enc_err_nxt)
	);

	bskic_digit_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (dec_cnt_q),
		.wdata (sat_rem(div_rem)),
		.re    (mem_re),
		.raddr (dec_cnt_q),
		.rdata (mem_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ML_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = dec_val_q;
		enc_ctrl     = '0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		out_load     = 1'b0;
		out_kind     = KIND_INDEX;
		out_index    = '0;
		out_digit    = '0;
		out_last     = 1'b0;
		out_err      = 1'b0;
		in_ready     = (state_q == ST_IDLE) && slot_free && !cfg_we;
		accept       = req.valid && in_ready;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_ENCODE) begin
						enc_ctrl.take = 1'b1;
						enc_ctrl.last = req.last_digit;
						if (req.last_digit) begin
							out_load  = 1'b1;
							out_kind  = KIND_INDEX;
							out_index = IDX_FIELD_W'(enc_index_nxt);
							out_last  = 1'b1;
							out_err   = enc_err_nxt;
						end
					end else if (req.length_in != '0) begin
						if (req.length_in > max_len_q) begin
							out_load = 1'b1;
							out_kind = KIND_DIGIT;
							out_last = 1'b1;
							out_err  = 1'b1;
						end else begin
							state_d = ST_DEC_DIV;
						end
					end
				end
			end
			ST_ML_INIT: begin
				div_start    = 1'b1;
				div_dividend = FULL_SCALE;
				state_d      = ST_ML_RUN;
			end
			ST_ML_RUN: begin
				if (div_stat.done) begin
					if (div_quot != '0) begin
						div_start    = 1'b1;
						div_dividend = div_quot;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DEC_DIV: begin
				if (dec_cnt_q == '0) begin
					state_d = ST_DEC_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DEC_WAIT;
				end
			end
			ST_DEC_WAIT: begin
				if (div_stat.done) begin
					mem_we  = 1'b1;
					state_d = ST_DEC_DIV;
				end
			end
			ST_DEC_RD: begin
				mem_re  = 1'b1;
				state_d = ST_DEC_OUT;
			end
			ST_DEC_OUT: begin
				if (slot_free) begin
					out_load  = 1'b1;
					out_kind  = KIND_DIGIT;
					out_digit = (dec_cnt_q == '0) ? sat_wide(dec_val_q) : mem_rdata;
					out_last  = (dec_cnt_q == dec_lastpos_q);
					out_err   = dec_err_q;
					state_d   = out_last ? ST_IDLE : ST_DEC_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// A new radix restarts the length search
		if (cfg_we) begin
			state_d = ST_ML_INIT;
		end
	end

	// Radix and maximum length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= ALPHA_RESET;
			max_len_q <= '0;
		end else begin
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
			end
			if (state_q == ST_ML_INIT) begin
				max_len_q <= '0;
			end else if (state_q == ST_ML_RUN && div_stat.done && div_quot != '0) begin
				max_len_q <= max_len_q + LEN_W'(1);
			end
		end
	end

	// Decode position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_cnt_q <= '0;
		end else if (state_q == ST_IDLE && accept && req.req_type == REQ_DECODE) begin
			dec_cnt_q <= len_m1[MEM_AW-1:0];
		end else if (state_q == ST_DEC_WAIT && div_stat.done) begin
			dec_cnt_q <= dec_cnt_q - MEM_AW'(1);
		end else if (state_q == ST_DEC_OUT && out_load && !out_last) begin
			dec_cnt_q <= dec_cnt_q + MEM_AW'(1);
		end
	end

	// Decode value, last position and range error
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && req.req_type == REQ_DECODE) begin
			dec_val_q     <= DIV_W'(req.index_in & IDX_MASK);
			dec_lastpos_q <= len_m1[MEM_AW-1:0];
			dec_err_q     <= (req.index_in & ~IDX_MASK) != '0;
		end else if (state_q == ST_DEC_WAIT && div_stat.done) begin
			dec_val_q <= div_quot;
		end else if (state_q == ST_DEC_DIV && dec_cnt_q == '0) begin
			// leading quotient at or above sigma means index >= sigma^length
			dec_err_q <= dec_err_q || (dec_val_q >= DIV_W'(radix));
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_kind_q  <= out_kind;
			res_index_q <= out_index;
			res_digit_q <= out_digit;
			res_last_q  <= out_last;
			res_err_q   <= out_err;
		end
	end

	assign req.ready       = in_ready;
	assign res.valid       = res_valid_q;
	assign res.result_kind = res_kind_q;
	assign res.index_out   = res_index_q;
	assign res.digit_out   = res_digit_q;
	assign res.last_out    = res_last_q;
	assign res.error_flag  = res_err_q;

	// Checks

	// nothing is emitted while a division is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !out_load)
		else $error("result loaded while divider busy");

	// the length search never passes the widest string
	assert property (@(posedge clk) disable iff (!arst_n)
		max_len_q <= LEN_W'(MEM_DEPTH))
		else $error("maximum length out of range");

	// digit emission stays within the requested length
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC_OUT || state_q == ST_DEC_RD) |-> dec_cnt_q <= dec_lastpos_q)
		else $error("decode position past last digit");

	// divider completion follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> $past(div_stat.busy))
		else $error("divider done without work");

endmodule

`default_nettype wire
